// ===== hw/rtl/touch_swipe_tap_classifier_top_defines.svh =====
// assertion helpers used by the top-level rtl file
`ifndef TOUCH_SWIPE_TAP_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_SWIPE_TAP_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSTC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tstc check failed");

// next-cycle implication, checked out of reset
`define TSTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tstc check failed");

`endif

// ===== hw/rtl/tstc_pkg.sv =====
`default_nettype none

package tstc_pkg;

    localparam int COORD_BITS = 12;
    localparam int PAGE_BITS  = 8;
    localparam int HOLD_BITS  = 16;
    localparam int TIME_BITS  = 32;
    localparam int ALU_W      = 32;
    localparam int CFG_IDX_W  = 3;

    // gesture codes
    localparam logic [1:0] GEST_NONE  = 2'd0;
    localparam logic [1:0] GEST_LEFT  = 2'd1;
    localparam logic [1:0] GEST_RIGHT = 2'd2;
    localparam logic [1:0] GEST_TAP   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN_DX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MAX_DY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_DELTA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS    = 3'd4;

    typedef logic [ALU_W-1:0] alu_word_t;

    typedef struct packed {
        logic                  touched;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]  now_ms;
    } sample_t;

    typedef struct packed {
        logic [1:0]            gesture;
        logic [PAGE_BITS-1:0]  page_index;
        logic [COORD_BITS-1:0] tap_x;
        logic [COORD_BITS-1:0] tap_y;
    } result_t;

    typedef struct packed {
        logic      sub;
        alu_word_t a;
        alu_word_t b;
    } alu_req_t;

    typedef struct packed {
        logic      carry;
        alu_word_t value;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/touch_swipe_tap_classifier_top.sv =====
// Touch swipe and tap classifier. One touch sample is taken per request; every
// sample gives one result with the gesture, the page index and the tap point.
// A touched sample, or an untouched one with no press open, goes straight to
// the output state. A release runs a sequencer over one shared 32-bit
// add/subtract unit: time check, travel magnitudes and threshold compares
// (a release inside the holdoff stops after the time check), and a swipe then
// forms the dividend (page plus one for left, page plus total less one for
// right) and runs 9 restoring remainder steps for the page wrap. sample_stall
// stays high while an item is in work. The result sits in an output register,
// so the next sample is taken while a result waits; an item cannot finish
// until that register is free.
`default_nettype none

`include "touch_swipe_tap_classifier_top_defines.svh"

module touch_swipe_tap_classifier_top (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  sample_valid,
    output logic                                 sample_stall,
    input  wire tstc_pkg::sample_t               sample,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output tstc_pkg::result_t                    result,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [tstc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [tstc_pkg::HOLD_BITS-1:0]        cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ELAP = 4'd1;
    localparam logic [3:0] S_HOLD = 4'd2;
    localparam logic [3:0] S_DX1  = 4'd3;
    localparam logic [3:0] S_DX2  = 4'd4;
    localparam logic [3:0] S_DY1  = 4'd5;
    localparam logic [3:0] S_DY2  = 4'd6;
    localparam logic [3:0] S_CMIN = 4'd7;
    localparam logic [3:0] S_CDY  = 4'd8;
    localparam logic [3:0] S_CTX  = 4'd9;
    localparam logic [3:0] S_CTY  = 4'd10;
    localparam logic [3:0] S_PRE1 = 4'd11;
    localparam logic [3:0] S_PRE2 = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    localparam int CB = tstc_pkg::COORD_BITS;
    localparam int PB = tstc_pkg::PAGE_BITS;
    localparam int DB = tstc_pkg::PAGE_BITS + 1;
    localparam logic [3:0] DIV_LAST = 4'(DB - 1);

    // configuration
    logic [PB-1:0]                  page_count_reg;
    logic [CB-1:0]                  swipe_min_dx_reg;
    logic [CB-1:0]                  swipe_max_dy_reg;
    logic [CB-1:0]                  tap_max_delta_reg;
    logic [tstc_pkg::HOLD_BITS-1:0] holdoff_ms_reg;

    // tracked state
    logic                           pressed_reg, pressed_next;
    logic [CB-1:0]                  start_x_reg, start_x_next;
    logic [CB-1:0]                  start_y_reg, start_y_next;
    logic [CB-1:0]                  recent_x_reg, recent_x_next;
    logic [CB-1:0]                  recent_y_reg, recent_y_next;
    logic [tstc_pkg::TIME_BITS-1:0] last_eval_reg, last_eval_next;
    logic [PB-1:0]                  page_reg, page_next;

    // sequencer working registers
    logic [3:0]                     state_reg, state_next;
    logic [tstc_pkg::TIME_BITS-1:0] now_reg, now_next;
    logic [tstc_pkg::TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                           dx_neg_reg, dx_neg_next;
    logic                           dy_neg_reg, dy_neg_next;
    logic [CB-1:0]                  adx_reg, adx_next;
    logic [CB-1:0]                  ady_reg, ady_next;
    logic                           big_dx_reg, big_dx_next;
    logic                           dy_ok_reg, dy_ok_next;
    logic                           tap_dx_reg, tap_dx_next;
    logic [1:0]                     gest_reg, gest_next;
    logic [DB-1:0]                  div_reg, div_next;
    logic [PB-1:0]                  rem_reg, rem_next;
    logic [3:0]                     cnt_reg, cnt_next;

    logic                           out_valid_reg, out_valid_next;
    tstc_pkg::result_t              out_reg, out_next;

    tstc_pkg::alu_req_t             alu_req;
    tstc_pkg::alu_rsp_t             alu_rsp;

    logic [PB-1:0]                  total;
    logic [DB-1:0]                  shifted;
    logic                           out_free;
    logic                           take;

    tstc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign total    = (page_count_reg == '0) ? PB'(1) : page_count_reg;
    assign shifted  = {rem_reg, div_reg[DB-1]};
    assign out_free = !out_valid_reg || !result_stall;
    assign take     = sample_valid && !sample_stall;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

    // operand select for the shared unit
    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (state_reg)
            S_ELAP:
            begin
                alu_req.a = now_reg;
                alu_req.b = last_eval_reg;
            end
            S_HOLD:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(holdoff_ms_reg);
                alu_req.b = elapsed_reg;
            end
            S_DX1:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(recent_x_reg);
                alu_req.b = tstc_pkg::alu_word_t'(start_x_reg);
            end
            S_DX2:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(start_x_reg);
                alu_req.b = tstc_pkg::alu_word_t'(recent_x_reg);
            end
            S_DY1:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(recent_y_reg);
                alu_req.b = tstc_pkg::alu_word_t'(start_y_reg);
            end
            S_DY2:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(start_y_reg);
                alu_req.b = tstc_pkg::alu_word_t'(recent_y_reg);
            end
            S_CMIN:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(swipe_min_dx_reg);
                alu_req.b = tstc_pkg::alu_word_t'(adx_reg);
            end
            S_CDY:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(ady_reg);
                alu_req.b = tstc_pkg::alu_word_t'(swipe_max_dy_reg);
            end
            S_CTX:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(adx_reg);
                alu_req.b = tstc_pkg::alu_word_t'(tap_max_delta_reg);
            end
            S_CTY:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(ady_reg);
                alu_req.b = tstc_pkg::alu_word_t'(tap_max_delta_reg);
            end
            S_PRE1:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = tstc_pkg::alu_word_t'(page_reg);
                alu_req.b   = (gest_reg == tstc_pkg::GEST_LEFT)
                              ? tstc_pkg::alu_word_t'(1)
                              : tstc_pkg::alu_word_t'(total);
            end
            S_PRE2:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(div_reg);
                alu_req.b = tstc_pkg::alu_word_t'(1);
            end
            S_DIV:
            begin
                alu_req.a = tstc_pkg::alu_word_t'(shifted);
                alu_req.b = tstc_pkg::alu_word_t'(total);
            end
            default:
            begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pressed_next   = pressed_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        recent_x_next  = recent_x_reg;
        recent_y_next  = recent_y_reg;
        last_eval_next = last_eval_reg;
        page_next      = page_reg;
        state_next     = state_reg;
        now_next       = now_reg;
        elapsed_next   = elapsed_reg;
        dx_neg_next    = dx_neg_reg;
        dy_neg_next    = dy_neg_reg;
        adx_next       = adx_reg;
        ady_next       = ady_reg;
        big_dx_next    = big_dx_reg;
        dy_ok_next     = dy_ok_reg;
        tap_dx_next    = tap_dx_reg;
        gest_next      = gest_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    now_next   = sample.now_ms;
                    gest_next  = tstc_pkg::GEST_NONE;
                    state_next = S_OUT;
                    if (sample.touched)
                    begin
                        if (!pressed_reg)
                        begin
                            start_x_next = sample.pos_x;
                            start_y_next = sample.pos_y;
                        end
                        pressed_next  = 1'b1;
                        recent_x_next = sample.pos_x;
                        recent_y_next = sample.pos_y;
                    end
                    else if (pressed_reg)
                    begin
                        pressed_next = 1'b0;
                        state_next   = S_ELAP;
                    end
                end
            end
            S_ELAP:
            begin
                elapsed_next = alu_rsp.value;
                state_next   = S_HOLD;
            end
            S_HOLD:
            begin
                // borrow means elapsed exceeds the holdoff
                if (alu_rsp.carry)
                begin
                    last_eval_next = now_reg;
                    state_next     = S_DX1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DX1:
            begin
                dx_neg_next = alu_rsp.carry;
                adx_next    = alu_rsp.value[CB-1:0];
                state_next  = S_DX2;
            end
            S_DX2:
            begin
                if (dx_neg_reg)
                begin
                    adx_next = alu_rsp.value[CB-1:0];
                end
                state_next = S_DY1;
            end
            S_DY1:
            begin
                dy_neg_next = alu_rsp.carry;
                ady_next    = alu_rsp.value[CB-1:0];
                state_next  = S_DY2;
            end
            S_DY2:
            begin
                if (dy_neg_reg)
                begin
                    ady_next = alu_rsp.value[CB-1:0];
                end
                state_next = S_CMIN;
            end
            S_CMIN:
            begin
                big_dx_next = alu_rsp.carry;
                state_next  = S_CDY;
            end
            S_CDY:
            begin
                dy_ok_next = alu_rsp.carry;
                state_next = S_CTX;
            end
            S_CTX:
            begin
                tap_dx_next = alu_rsp.carry;
                state_next  = S_CTY;
            end
            S_CTY:
            begin
                if (big_dx_reg && dy_ok_reg)
                begin
                    gest_next  = dx_neg_reg ? tstc_pkg::GEST_LEFT : tstc_pkg::GEST_RIGHT;
                    state_next = S_PRE1;
                end
                else if (tap_dx_reg && alu_rsp.carry)
                begin
                    gest_next  = tstc_pkg::GEST_TAP;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PRE1:
            begin
                div_next = alu_rsp.value[DB-1:0];
                rem_next = '0;
                cnt_next = '0;
                state_next = (gest_reg == tstc_pkg::GEST_LEFT) ? S_DIV : S_PRE2;
            end
            S_PRE2:
            begin
                div_next   = alu_rsp.value[DB-1:0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring remainder, one dividend bit a step
                rem_next = alu_rsp.carry ? shifted[PB-1:0] : alu_rsp.value[PB-1:0];
                div_next = {div_reg[DB-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    page_next  = alu_rsp.carry ? shifted[PB-1:0] : alu_rsp.value[PB-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.gesture    = gest_reg;
                    out_next.page_index = page_reg;
                    out_next.tap_x      = (gest_reg == tstc_pkg::GEST_TAP) ? recent_x_reg : '0;
                    out_next.tap_y      = (gest_reg == tstc_pkg::GEST_TAP) ? recent_y_reg : '0;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg    <= PB'(1);
            swipe_min_dx_reg  <= CB'(35);
            swipe_max_dy_reg  <= CB'(70);
            tap_max_delta_reg <= CB'(20);
            holdoff_ms_reg    <= tstc_pkg::HOLD_BITS'(150);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tstc_pkg::REG_PAGE_COUNT:    page_count_reg    <= cfg_data[PB-1:0];
                tstc_pkg::REG_SWIPE_MIN_DX:  swipe_min_dx_reg  <= cfg_data[CB-1:0];
                tstc_pkg::REG_SWIPE_MAX_DY:  swipe_max_dy_reg  <= cfg_data[CB-1:0];
                tstc_pkg::REG_TAP_MAX_DELTA: tap_max_delta_reg <= cfg_data[CB-1:0];
                tstc_pkg::REG_HOLDOFF_MS:    holdoff_ms_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg   <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            recent_x_reg  <= '0;
            recent_y_reg  <= '0;
            last_eval_reg <= '0;
            page_reg      <= '0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pressed_reg   <= pressed_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            recent_x_reg  <= recent_x_next;
            recent_y_reg  <= recent_y_next;
            last_eval_reg <= last_eval_next;
            page_reg      <= page_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        dx_neg_reg  <= dx_neg_next;
        dy_neg_reg  <= dy_neg_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        big_dx_reg  <= big_dx_next;
        dy_ok_reg   <= dy_ok_next;
        tap_dx_reg  <= tap_dx_next;
        gest_reg    <= gest_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

    `TSTC_ASSERT_IMPL(a_rem_below_total, state_reg == S_DIV, rem_reg < total)
    `TSTC_ASSERT_IMPL(a_div_count_bound, state_reg == S_DIV, cnt_reg <= DIV_LAST)
    `TSTC_ASSERT_NEXT(a_touch_sets_press, take && sample.touched, pressed_reg)
    `TSTC_ASSERT_NEXT(a_out_loads, state_reg == S_OUT && out_free,
                      out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/tstc_alu.sv =====
`default_nettype none

module tstc_alu (
    input  wire tstc_pkg::alu_req_t req,
    output tstc_pkg::alu_rsp_t      rsp
);

    logic [tstc_pkg::ALU_W:0] sum;

    // carry is the borrow when subtracting
    always_comb
    begin
        if (req.sub)
        begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.carry = sum[tstc_pkg::ALU_W];
        rsp.value = sum[tstc_pkg::ALU_W-1:0];
    end

endmodule

`default_nettype wire
